/* rtl/rbs_pkg.sv */
// Shared types and constants for the running background subtraction block.
package rbs_pkg;

    // One 8-bit value per color channel: index 0 is blue, 1 is green, 2 is red.
    typedef logic [2:0][7:0] chan3_t;

    // Input beat fields.
    typedef struct packed {
        logic [15:0] pixel_index;
        logic        load_background;
        logic [7:0]  chan_b;
        logic [7:0]  chan_g;
        logic [7:0]  chan_r;
    } pixel_beat_t;

    // Result beat fields.
    typedef struct packed {
        logic [7:0] bg_b;
        logic [7:0] bg_g;
        logic [7:0] bg_r;
        logic [7:0] fg_b;
        logic [7:0] fg_g;
        logic [7:0] fg_r;
        logic       is_foreground;
    } result_beat_t;

    // Pixel as it sits in the read stage, waiting for the mean memory.
    typedef struct packed {
        logic [15:0] pixel_index;
        logic        in_range;
        logic        load;
        chan3_t      pix;
    } rd_stage_t;

    // Pixel after the threshold test, with the mean it was compared against.
    typedef struct packed {
        logic [15:0] pixel_index;
        logic        in_range;
        logic        load;
        logic        match;
        chan3_t      pix;
        chan3_t      mean;
    } cmp_stage_t;

    // Configuration register indexes.
    localparam logic CFG_MATCH_THRESHOLD = 1'b0;
    localparam logic CFG_ALPHA_Q16       = 1'b1;

    localparam int CFG_DATA_W = 17;

    // Reset values and the unit learning rate.
    localparam logic [7:0]  THRESH_RESET = 8'd60;
    localparam logic [16:0] ALPHA_RESET  = 17'd3277;
    localparam logic [16:0] ALPHA_ONE    = 17'h10000;

    // Width of one blend product: 17-bit weight times 8-bit channel.
    localparam int PROD_W = 25;

endpackage

/* rtl/running_background_subtract.sv */
// Running-average background subtraction: each accepted beat passes the read, compare,
// product and output registers. Throughput is one beat per cycle while m_ready is high;
// a beat whose pixel_index equals that of one of the up to three beats still before
// write-back waits until that beat writes its mean, as the mean memory is read-modify-write.
// Reset clears the valid bits and sets the threshold to 60 and alpha to 3277. The mean
// memory is not cleared; each pixel must be loaded before it is compared.
module running_background_subtract #(
    parameter int PIXELS = 65536
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  rbs_pkg::pixel_beat_t                s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output rbs_pkg::result_beat_t               m_data,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_index,
    input  logic [rbs_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int          ADDR_W    = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam logic [24:0] PIX_LIMIT = 25'(PIXELS);

    logic [7:0]          thresh_reg;
    logic [16:0]         alpha_reg;

    logic                rd_v_reg;
    logic                cmp_v_reg;
    logic                prod_v_reg;
    logic                out_v_reg;
    rbs_pkg::rd_stage_t  rd_reg;
    rbs_pkg::rd_stage_t  rd_next;

    rbs_pkg::cmp_stage_t cmp_stage;
    rbs_pkg::chan3_t     mem_data;
    rbs_pkg::chan3_t     new_mean;
    logic [15:0]         prod_index;
    logic                prod_in_range;

    logic                out_en;
    logic                prod_en;
    logic                cmp_en;
    logic                rd_en;
    logic                hazard;
    logic                accept;
    logic                mem_wr;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= rbs_pkg::THRESH_RESET;
            alpha_reg  <= rbs_pkg::ALPHA_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                rbs_pkg::CFG_MATCH_THRESHOLD: thresh_reg <= cfg_wdata[7:0];
                rbs_pkg::CFG_ALPHA_Q16:       alpha_reg  <= cfg_wdata[16:0];
                default:                      thresh_reg <= thresh_reg;
            endcase
        end
    end

    // Each stage loads when it is empty or its contents move on.
    assign out_en  = !out_v_reg || m_ready;
    assign prod_en = !prod_v_reg || out_en;
    assign cmp_en  = !cmp_v_reg || prod_en;
    assign rd_en   = !rd_v_reg || cmp_en;

    // Hold off a beat whose mean is still being updated further down the pipe.
    assign hazard = (rd_v_reg && rd_reg.in_range &&
                     (rd_reg.pixel_index == s_data.pixel_index)) ||
                    (cmp_v_reg && cmp_stage.in_range &&
                     (cmp_stage.pixel_index == s_data.pixel_index)) ||
                    (prod_v_reg && prod_in_range &&
                     (prod_index == s_data.pixel_index));

    assign s_ready = rd_en && !hazard;
    assign accept  = s_valid && s_ready;

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg   <= 1'b0;
            cmp_v_reg  <= 1'b0;
            prod_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end else begin
            if (rd_en) begin
                rd_v_reg <= accept;
            end
            if (cmp_en) begin
                cmp_v_reg <= rd_v_reg;
            end
            if (prod_en) begin
                prod_v_reg <= cmp_v_reg;
            end
            if (out_en) begin
                out_v_reg <= prod_v_reg;
            end
        end
    end

    // Read stage: capture the beat while the memory fetches its mean.
    always_comb begin
        rd_next.pixel_index = s_data.pixel_index;
        rd_next.in_range    = (25'(s_data.pixel_index) < PIX_LIMIT);
        rd_next.load        = s_data.load_background;
        rd_next.pix         = {s_data.chan_r, s_data.chan_g, s_data.chan_b};
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_reg <= rd_next;
        end
    end

    // The mean is written back as the beat leaves the product stage.
    assign mem_wr = prod_v_reg && out_en && prod_in_range;

    rbs_mean_mem #(
        .DEPTH  (PIXELS),
        .ADDR_W (ADDR_W)
    ) u_mean_mem (
        .aclk     (aclk),
        .rd_en    (accept),
        .rd_index (s_data.pixel_index),
        .rd_data  (mem_data),
        .wr_en    (mem_wr),
        .wr_index (prod_index),
        .wr_data  (new_mean)
    );

    rbs_match_stage u_match_stage (
        .aclk            (aclk),
        .load_en         (cmp_en),
        .rd_stage        (rd_reg),
        .mem_data        (mem_data),
        .match_threshold (thresh_reg),
        .cmp_stage       (cmp_stage)
    );

    rbs_blend_stage u_blend_stage (
        .aclk          (aclk),
        .prod_en       (prod_en),
        .out_en        (out_en),
        .cmp_stage     (cmp_stage),
        .alpha_q16     (alpha_reg),
        .prod_index    (prod_index),
        .prod_in_range (prod_in_range),
        .new_mean      (new_mean),
        .result        (m_data)
    );

    assign m_valid = out_v_reg;

endmodule

/* rtl/rbs_mean_mem.sv */
// Background mean memory: one write port, one read port with registered data.
module rbs_mean_mem #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16
) (
    input  logic            aclk,
    input  logic            rd_en,
    input  logic [15:0]     rd_index,
    output rbs_pkg::chan3_t rd_data,
    input  logic            wr_en,
    input  logic [15:0]     wr_index,
    input  rbs_pkg::chan3_t wr_data
);

    localparam int IDX_W = (ADDR_W > 16) ? ADDR_W : 16;

    rbs_pkg::chan3_t mem_reg [DEPTH];
    rbs_pkg::chan3_t rd_data_reg;

    logic [IDX_W-1:0]  rd_wide;
    logic [IDX_W-1:0]  wr_wide;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;

    // Fit the 16-bit pixel index to the address width of the memory.
    assign rd_wide = IDX_W'(rd_index);
    assign wr_wide = IDX_W'(wr_index);
    assign rd_addr = rd_wide[ADDR_W-1:0];
    assign wr_addr = wr_wide[ADDR_W-1:0];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port; the data register holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/rbs_match_stage.sv */
// Threshold test stage: compares each channel with its stored mean.
module rbs_match_stage (
    input  logic                aclk,
    input  logic                load_en,
    input  rbs_pkg::rd_stage_t  rd_stage,
    input  rbs_pkg::chan3_t     mem_data,
    input  logic [7:0]          match_threshold,
    output rbs_pkg::cmp_stage_t cmp_stage
);

    rbs_pkg::cmp_stage_t cmp_reg;
    rbs_pkg::cmp_stage_t cmp_next;
    rbs_pkg::chan3_t     mean;
    rbs_pkg::chan3_t     abs_diff;
    logic [2:0]          chan_ok;

    // A pixel outside the frame sees a zero mean.
    assign mean = rd_stage.in_range ? mem_data : '0;

    // Absolute difference per channel, then the below-threshold test.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            abs_diff[c] = (rd_stage.pix[c] >= mean[c]) ? (rd_stage.pix[c] - mean[c])
                                                       : (mean[c] - rd_stage.pix[c]);
            chan_ok[c]  = (abs_diff[c] < match_threshold);
        end
    end

    always_comb begin
        cmp_next.pixel_index = rd_stage.pixel_index;
        cmp_next.in_range    = rd_stage.in_range;
        cmp_next.load        = rd_stage.load;
        cmp_next.match       = &chan_ok;
        cmp_next.pix         = rd_stage.pix;
        cmp_next.mean        = mean;
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            cmp_reg <= cmp_next;
        end
    end

    assign cmp_stage = cmp_reg;

endmodule

/* rtl/rbs_blend_stage.sv */
// Blend stages: weight products, then the new mean and the result beat.
module rbs_blend_stage (
    input  logic                  aclk,
    input  logic                  prod_en,
    input  logic                  out_en,
    input  rbs_pkg::cmp_stage_t   cmp_stage,
    input  logic [16:0]           alpha_q16,
    output logic [15:0]           prod_index,
    output logic                  prod_in_range,
    output rbs_pkg::chan3_t       new_mean,
    output rbs_pkg::result_beat_t result
);

    // Product stage registers.
    logic [15:0]                         idx_reg;
    logic                                in_range_reg;
    logic                                load_reg;
    logic                                match_reg;
    rbs_pkg::chan3_t                     pix_reg;
    rbs_pkg::chan3_t                     mean_reg;
    logic [2:0][rbs_pkg::PROD_W-1:0]     keep_prod_reg;
    logic [2:0][rbs_pkg::PROD_W-1:0]     new_prod_reg;

    rbs_pkg::result_beat_t               result_reg;
    rbs_pkg::result_beat_t               result_next;

    logic [16:0]                         alpha_sat;
    logic [16:0]                         keep_w;
    logic [rbs_pkg::PROD_W-1:0]          blend_sum;
    rbs_pkg::chan3_t                     blended;
    rbs_pkg::chan3_t                     fg;
    logic                                background;

    // Learning rates above one saturate to one.
    assign alpha_sat = alpha_q16[16] ? rbs_pkg::ALPHA_ONE : alpha_q16;
    assign keep_w    = rbs_pkg::ALPHA_ONE - alpha_sat;

    // Weight the old mean and the new pixel, one multiplier pair per channel.
    always_ff @(posedge aclk) begin
        if (prod_en) begin
            idx_reg      <= cmp_stage.pixel_index;
            in_range_reg <= cmp_stage.in_range;
            load_reg     <= cmp_stage.load;
            match_reg    <= cmp_stage.match;
            pix_reg      <= cmp_stage.pix;
            mean_reg     <= cmp_stage.mean;
            for (int c = 0; c < 3; c++) begin
                keep_prod_reg[c] <= rbs_pkg::PROD_W'(keep_w) *
                                    rbs_pkg::PROD_W'(cmp_stage.mean[c]);
                new_prod_reg[c]  <= rbs_pkg::PROD_W'(alpha_sat) *
                                    rbs_pkg::PROD_W'(cmp_stage.pix[c]);
            end
        end
    end

    // Sum the products and keep the integer part as the blended mean.
    always_comb begin
        blend_sum = '0;
        for (int c = 0; c < 3; c++) begin
            blend_sum  = keep_prod_reg[c] + new_prod_reg[c];
            blended[c] = blend_sum[23:16];
        end
    end

    // Select the new mean and the foreground difference.
    always_comb begin
        background = load_reg || match_reg;
        for (int c = 0; c < 3; c++) begin
            if (load_reg) begin
                new_mean[c] = pix_reg[c];
            end else if (match_reg) begin
                new_mean[c] = blended[c];
            end else begin
                new_mean[c] = mean_reg[c];
            end
            fg[c] = background ? 8'd0 : (pix_reg[c] - mean_reg[c]);
        end
    end

    always_comb begin
        result_next.bg_b          = new_mean[0];
        result_next.bg_g          = new_mean[1];
        result_next.bg_r          = new_mean[2];
        result_next.fg_b          = fg[0];
        result_next.fg_g          = fg[1];
        result_next.fg_r          = fg[2];
        result_next.is_foreground = !background;
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (out_en) begin
            result_reg <= result_next;
        end
    end

    assign prod_index    = idx_reg;
    assign prod_in_range = in_range_reg;
    assign result        = result_reg;

endmodule

/* tb/sv/tb.sv */
// Testbench for running_background_subtract: directed and random pixel traffic.
`timescale 1ns / 100ps

module tb;

    localparam int NUM_PIXELS = 65536;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_BEATS = 230;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    rbs_pkg::pixel_beat_t           s_data;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    rbs_pkg::result_beat_t          m_data;
    logic                           cfg_wr_en;
    logic                           cfg_index;
    logic [rbs_pkg::CFG_DATA_W-1:0] cfg_wdata;

    // Shadow of the block's registers and mean memory.
    logic [7:0]      thr_shadow;
    logic [16:0]     alpha_shadow;
    rbs_pkg::chan3_t mean_shadow [NUM_PIXELS];
    bit              mean_loaded [NUM_PIXELS];

    rbs_pkg::result_beat_t pending_results [$];

    int send_idle_pct;
    int recv_stall_pct;
    int fail_count;
    int beats_checked;
    int fg_seen;
    int loads_sent;
    int settings_count;
    int quiet_cycles;

    running_background_subtract #(
        .PIXELS(NUM_PIXELS)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Predict one result beat and update the shadow mean for that pixel.
    function automatic rbs_pkg::result_beat_t predict_subtraction(rbs_pkg::pixel_beat_t beat);
        rbs_pkg::chan3_t       pix;
        rbs_pkg::chan3_t       mean;
        rbs_pkg::chan3_t       bg;
        rbs_pkg::chan3_t       fg;
        logic                  all_match;
        logic [16:0]           weight;
        logic [31:0]           blended;
        logic [7:0]            diff;
        rbs_pkg::result_beat_t res;
        pix = {beat.chan_r, beat.chan_g, beat.chan_b};
        mean = mean_shadow[beat.pixel_index];
        weight = (alpha_shadow > rbs_pkg::ALPHA_ONE) ? rbs_pkg::ALPHA_ONE : alpha_shadow;
        all_match = 1'b1;
        bg = pix;
        fg = '0;
        if (!beat.load_background) begin
            for (int c = 0; c < 3; c++) begin
                diff = (pix[c] >= mean[c]) ? pix[c] - mean[c] : mean[c] - pix[c];
                if (diff >= thr_shadow) begin
                    all_match = 1'b0;
                end
            end
            for (int c = 0; c < 3; c++) begin
                if (all_match) begin
                    blended = (32'(rbs_pkg::ALPHA_ONE) - 32'(weight)) * 32'(mean[c])
                              + 32'(weight) * 32'(pix[c]);
                    bg[c] = blended[23:16];
                end else begin
                    bg[c] = mean[c];
                    fg[c] = pix[c] - mean[c];
                end
            end
        end else begin
            loads_sent++;
        end
        mean_shadow[beat.pixel_index] = bg;
        mean_loaded[beat.pixel_index] = 1'b1;
        res.bg_b = bg[0];
        res.bg_g = bg[1];
        res.bg_r = bg[2];
        res.fg_b = fg[0];
        res.fg_g = fg[1];
        res.fg_r = fg[2];
        res.is_foreground = !beat.load_background && !all_match;
        return res;
    endfunction

    function automatic rbs_pkg::pixel_beat_t make_pixel(logic [15:0] idx, logic load,
                                               logic [7:0] b, logic [7:0] g, logic [7:0] r);
        rbs_pkg::pixel_beat_t beat;
        beat.pixel_index = idx;
        beat.load_background = load;
        beat.chan_b = b;
        beat.chan_g = g;
        beat.chan_r = r;
        return beat;
    endfunction

    // A channel value spread around the mean, a little past the threshold on both sides.
    function automatic logic [7:0] near_value(logic [7:0] mean);
        int span;
        int v;
        span = int'(thr_shadow) + 3;
        v = int'(mean) + int'($urandom_range(2 * span)) - span;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    function automatic void set_idle(idle_mode_t mode);
        send_idle_pct = (mode == IDLE_SEND) ? 74 : (mode == IDLE_BOTH) ? 6 : 0;
        recv_stall_pct = (mode == IDLE_RECV) ? 74 : (mode == IDLE_BOTH) ? 6 : 0;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Send one pixel beat after a random gap and record its prediction once accepted.
    task automatic send_pixel(input rbs_pkg::pixel_beat_t beat);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= beat;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_subtraction(beat));
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Write both registers while the pipeline is empty.
    task automatic write_config(input logic [7:0] thr, input logic [16:0] alpha);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= rbs_pkg::CFG_MATCH_THRESHOLD;
        cfg_wdata <= rbs_pkg::CFG_DATA_W'(thr);
        @(posedge aclk);
        cfg_index <= rbs_pkg::CFG_ALPHA_Q16;
        cfg_wdata <= alpha;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        thr_shadow = thr;
        alpha_shadow = alpha;
        settings_count++;
    endtask

    // Loads at the address and channel extremes, then the threshold boundary and wraparound.
    task automatic test_load_and_compare();
        set_idle(IDLE_NONE);
        send_pixel(make_pixel(16'h0000, 1'b1, 8'd0, 8'd0, 8'd0));
        send_pixel(make_pixel(16'hFFFF, 1'b1, 8'd255, 8'd255, 8'd255));
        send_pixel(make_pixel(16'h5A5A, 1'b1, 8'd100, 8'd150, 8'd200));
        send_pixel(make_pixel(16'hA5A5, 1'b1, 8'd1, 8'd2, 8'd3));
        send_pixel(make_pixel(16'h0000, 1'b0, 8'd59, 8'd59, 8'd59));
        send_pixel(make_pixel(16'hFFFF, 1'b0, 8'd195, 8'd196, 8'd255));
        send_pixel(make_pixel(16'h5A5A, 1'b0, 8'd160, 8'd150, 8'd200));
        send_pixel(make_pixel(16'h5A5A, 1'b0, 8'd40, 8'd150, 8'd200));
        send_pixel(make_pixel(16'h5A5A, 1'b0, 8'd101, 8'd149, 8'd199));
        send_pixel(make_pixel(16'hA5A5, 1'b0, 8'd0, 8'd255, 8'd3));
        // Same address back to back exercises the read-modify-write hazard.
        send_pixel(make_pixel(16'h0007, 1'b1, 8'd10, 8'd20, 8'd30));
        send_pixel(make_pixel(16'h0007, 1'b0, 8'd12, 8'd22, 8'd32));
        send_pixel(make_pixel(16'h0007, 1'b0, 8'd250, 8'd20, 8'd30));
    endtask

    // Zero and full thresholds, zero and unit learning rates, and a saturating rate.
    task automatic test_config_extremes();
        write_config(8'd0, rbs_pkg::ALPHA_ONE);
        send_pixel(make_pixel(16'h0000, 1'b0, 8'd0, 8'd0, 8'd0));
        send_pixel(make_pixel(16'h0100, 1'b1, 8'd9, 8'd9, 8'd9));
        send_pixel(make_pixel(16'h0100, 1'b0, 8'd9, 8'd9, 8'd9));
        write_config(8'd255, 17'd0);
        send_pixel(make_pixel(16'hFFFF, 1'b0, 8'd0, 8'd0, 8'd0));
        send_pixel(make_pixel(16'h5A5A, 1'b0, 8'd200, 8'd10, 8'd100));
        write_config(8'd255, 17'h1FFFF);
        send_pixel(make_pixel(16'h5A5A, 1'b0, 8'd7, 8'd8, 8'd9));
        write_config(8'd255, 17'd1);
        send_pixel(make_pixel(16'hA5A5, 1'b0, 8'd255, 8'd0, 8'd128));
    endtask

    // Mostly load-then-compare traffic on a small address pool, with scattered loads elsewhere.
    task automatic test_random_traffic();
        logic [7:0]  thr_list [8] = '{8'd60, 8'd0, 8'd255, 8'd20, 8'd0, 8'd128, 8'd0, 8'd40};
        logic [16:0] alpha_list [8] = '{17'd3277, 17'h1FFFF, 17'd0, 17'h10000,
                                        17'd0, 17'd1, 17'd0, 17'd32768};
        logic [15:0]          pool [6];
        rbs_pkg::pixel_beat_t beat;
        rbs_pkg::chan3_t      mean;
        int                   kind;
        for (int phase = 0; phase < 8; phase++) begin
            if (phase == 4 || phase == 6) begin
                thr_list[phase] = 8'($urandom_range(255));
                alpha_list[phase] = 17'($urandom_range(131071));
            end
            write_config(thr_list[phase], alpha_list[phase]);
            set_idle(idle_mode_t'(phase % 4));
            foreach (pool[k]) pool[k] = 16'($urandom_range(65535));
            for (int n = 0; n < PHASE_BEATS; n++) begin
                kind = $urandom_range(99);
                beat.pixel_index = (kind < 75) ? pool[$urandom_range(5)]
                                               : 16'($urandom_range(65535));
                beat.chan_b = 8'($urandom_range(255));
                beat.chan_g = 8'($urandom_range(255));
                beat.chan_r = 8'($urandom_range(255));
                beat.load_background = !mean_loaded[beat.pixel_index] ||
                                       (kind >= 65 && kind < 75);
                if (!beat.load_background && kind < 52) begin
                    mean = mean_shadow[beat.pixel_index];
                    beat.chan_b = near_value(mean[0]);
                    beat.chan_g = near_value(mean[1]);
                    beat.chan_r = near_value(mean[2]);
                end
                send_pixel(beat);
            end
        end
    endtask

    // Receiver back-pressure.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each result beat with the oldest prediction.
    always @(posedge aclk) begin
        rbs_pkg::result_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("Result beat arrived with no prediction pending");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("bg_b", want.bg_b, m_data.bg_b);
                check_field("bg_g", want.bg_g, m_data.bg_g);
                check_field("bg_r", want.bg_r, m_data.bg_r);
                check_field("fg_b", want.fg_b, m_data.fg_b);
                check_field("fg_g", want.fg_g, m_data.fg_g);
                check_field("fg_r", want.fg_r, m_data.fg_r);
                check_field("is_foreground", 8'(want.is_foreground),
                            8'(m_data.is_foreground));
                beats_checked++;
                if (want.is_foreground) fg_seen++;
            end
        end
    end

    // Watchdog: end the run if no beat moves on either channel for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired after %0d quiet cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_wr_en = 1'b0;
        cfg_index = rbs_pkg::CFG_MATCH_THRESHOLD;
        cfg_wdata = '0;
        thr_shadow = rbs_pkg::THRESH_RESET;
        alpha_shadow = rbs_pkg::ALPHA_RESET;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fail_count = 0;
        beats_checked = 0;
        fg_seen = 0;
        loads_sent = 0;
        settings_count = 1;
        quiet_cycles = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_load_and_compare();
        test_config_extremes();
        test_random_traffic();

        wait_idle();
        if (pending_results.size() != 0) begin
            $error("%0d predicted results never arrived", pending_results.size());
            fail_count++;
        end
        $display("Checked %0d result beats (%0d loads, %0d foreground) over %0d settings",
                 beats_checked, loads_sent, fg_seen, settings_count);
        $display("of threshold and learning rate under four sender/receiver idle patterns.");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
